// ===== hw/rtl/kvh_pkg.sv =====
`default_nettype none

package kvh_pkg;

    // Fixed field widths of the request and result items.
    localparam int KEY_W   = 8;
    localparam int FREQ_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_KEY   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROLLING  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_KEYS = 1'd1;

    localparam logic [KEY_W-1:0]        NUM_KEYS_RESET = 8'd88;
    localparam logic [KEY_W-1:0]        DISTINCT_MAX   = 8'hFF;
    localparam logic signed [KEY_W-1:0] NO_KEY         = -8'sd1;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [KEY_W-1:0] key_index;
        logic [FREQ_W-1:0]       frequency_word;
    } kvh_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] voted_key;
        logic [FREQ_W-1:0]       frequency_out;
    } kvh_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } kvh_state_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic s_ready;
        logic do_clear;
        logic do_roll;
        logic rd_key;
        logic upd;
        logic scan_init;
        logic scan_issue;
        logic load_out;
    } seq_ctl_t;

    // Controls of the shared compare unit.
    typedef struct packed {
        logic init;
        logic cmp;
    } vote_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kvh_ram.sv =====
`default_nettype none

module kvh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kvh_vote.sv =====
`default_nettype none

module kvh_vote
    import kvh_pkg::*;
#(
    parameter int SLOT_W     = 7,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire vote_ctl_t               ctl,
    input  wire logic [COUNT_BITS-1:0]   rd_count,
    input  wire logic [SLOT_W-1:0]       rd_addr,
    input  wire logic signed [KEY_W-1:0] sole_key,
    input  wire logic                    sole_valid,
    input  wire logic [KEY_W-1:0]        distinct,
    output logic signed [KEY_W-1:0]      vote
);

    localparam int CMP_W = (COUNT_BITS > KEY_W) ? COUNT_BITS : KEY_W;

    logic [COUNT_BITS-1:0]   best_cnt_reg, best_cnt_next;
    logic signed [KEY_W-1:0] best_key_reg, best_key_next;
    logic [COUNT_BITS-1:0]   best_cnt_eff;
    logic signed [KEY_W-1:0] best_key_eff;
    logic [KEY_W-1:0]        half;

    // A sole entry with a negative key sorts ahead of every slot, so it seeds the scan.
    always_comb begin
        best_cnt_next = best_cnt_reg;
        best_key_next = best_key_reg;
        if (ctl.init) begin
            if (sole_valid && sole_key[KEY_W-1]) begin
                best_cnt_next = COUNT_BITS'(1);
                best_key_next = sole_key;
            end else begin
                best_cnt_next = '0;
                best_key_next = NO_KEY;
            end
        end else if (ctl.cmp && (rd_count > best_cnt_reg)) begin
            best_cnt_next = rd_count;
            best_key_next = KEY_W'(rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        best_cnt_reg <= best_cnt_next;
        best_key_reg <= best_key_next;
    end

    // A sole entry beyond the slots sorts last and wins only over an empty histogram.
    always_comb begin
        if (sole_valid && !sole_key[KEY_W-1] && (best_cnt_reg == '0)) begin
            best_cnt_eff = COUNT_BITS'(1);
            best_key_eff = sole_key;
        end else begin
            best_cnt_eff = best_cnt_reg;
            best_key_eff = best_key_reg;
        end
        half = distinct >> 1;
        if ((distinct != '0) && (CMP_W'(best_cnt_eff) > CMP_W'(half))) begin
            vote = best_key_eff;
        end else begin
            vote = NO_KEY;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kvh_seq.sv =====
`default_nettype none

module kvh_seq
    import kvh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic              rolling,
    input  wire logic              countable,
    input  wire logic              scan_done,
    input  wire logic              out_free,
    output seq_ctl_t               ctl
);

    kvh_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (func)
                        FUNC_KEY: begin
                            if (rolling) begin
                                state_next = ST_DONE;
                            end else if (countable) begin
                                state_next = ST_UPDATE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_QUERY: state_next = ST_SCAN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPDATE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctl.s_ready = 1'b1;
                if (s_valid) begin
                    case (func)
                        FUNC_CLEAR: ctl.do_clear = 1'b1;
                        FUNC_KEY: begin
                            if (rolling) begin
                                ctl.do_roll = 1'b1;
                            end else if (countable) begin
                                ctl.rd_key = 1'b1;
                            end else begin
                                ctl.scan_init = 1'b1;
                            end
                        end
                        FUNC_QUERY: ctl.scan_init = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_UPDATE: begin
                ctl.upd       = 1'b1;
                ctl.scan_init = 1'b1;
            end
            ST_SCAN: ctl.scan_issue = !scan_done;
            ST_DONE: ctl.load_out   = out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/key_vote_histogram_top.sv =====
// Key vote histogram: a majority vote over recognized keys.
//
// Requests enter on the s_ channel (valid/ready) and carry a function code,
// a key index and a frequency word. A key request in record mode adds one vote
// to its key if counted and returns the voted key; in rolling mode it replaces
// the store with that key and echoes it. A query returns the current vote with
// a zero frequency. A clear request empties the store and returns nothing.
// Results leave on the m_ channel (valid/ready) from an output register.
//
// The block works on one request at a time. A record-mode key request reads
// and updates the count of a counted key and then scans the count memory; a
// query only scans, and a rolling request and a clear do no scan. The scan
// reads one slot per cycle through the single read port of the count memory
// into one shared compare unit.
//
// Reset (aresetn low at a clock edge) empties the store through per-slot valid
// bits, drops any pending result and restores record mode with 88 keys.
// A stalled receiver holds the result in the output register; the block still
// accepts the next request, but cannot hand over a new result until the held
// one is taken.
`default_nettype none

module key_vote_histogram_top
    import kvh_pkg::*;
#(
    parameter int KEY_SLOTS  = 128,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire kvh_in_t               s_req,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output kvh_out_t                   m_res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SLOT_W = $clog2(KEY_SLOTS);
    localparam int IDX_W  = SLOT_W + 1;

    seq_ctl_t  ctl;
    vote_ctl_t vote_ctl;

    // Configuration registers.
    logic             rolling_reg;
    logic [KEY_W-1:0] nkeys_reg;

    // Store state beside the count memory.
    logic [KEY_SLOTS-1:0]    slot_valid_reg;
    logic [KEY_W-1:0]        distinct_reg;
    logic signed [KEY_W-1:0] sole_key_reg;
    logic                    sole_valid_reg;

    // The request being worked on.
    logic signed [KEY_W-1:0] key_reg;
    logic [SLOT_W-1:0]       key_slot_reg;
    logic [FREQ_W-1:0]       freq_reg;
    logic                    echo_reg;

    // Scan bookkeeping.
    logic [IDX_W-1:0]  idx_reg;
    logic              pend_reg;
    logic [SLOT_W-1:0] addr_reg;
    logic              scan_done;

    // Output register.
    logic     m_valid_reg;
    kvh_out_t m_res_reg;
    logic     out_free;

    // Request decode.
    logic signed [KEY_W-1:0] s_key;
    logic                    s_in_slot;
    logic                    s_countable;
    logic [SLOT_W-1:0]       s_slot;
    logic                    acc;

    // Memory ports.
    logic                  ram_we, ram_re;
    logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
    logic [COUNT_BITS-1:0] upd_count, upd_inc, scan_count;
    logic signed [KEY_W-1:0] vote;

    assign s_key       = s_req.key_index;
    assign s_in_slot   = !s_key[KEY_W-1] && ({1'b0, s_key} < (KEY_W + 1)'(KEY_SLOTS));
    assign s_countable = s_in_slot && ($unsigned(s_key) < nkeys_reg);
    assign s_slot      = s_key[SLOT_W-1:0];
    assign acc         = s_valid && ctl.s_ready;
    assign s_ready     = ctl.s_ready;

    assign scan_done = (idx_reg == IDX_W'(KEY_SLOTS));
    assign out_free  = !m_valid_reg || m_ready;

    kvh_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .func      (s_req.func),
        .rolling   (rolling_reg),
        .countable (s_countable),
        .scan_done (scan_done),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rolling_reg <= 1'b0;
            nkeys_reg   <= NUM_KEYS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROLLING:  rolling_reg <= cfg_wdata[0];
                REG_NUM_KEYS: nkeys_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A slot whose valid bit is low reads as a zero count, so clearing the
    // store never has to touch the memory itself.
    assign upd_count  = slot_valid_reg[key_slot_reg] ? ram_rdata : '0;
    assign upd_inc    = (upd_count == '1) ? upd_count : upd_count + COUNT_BITS'(1);
    assign scan_count = slot_valid_reg[addr_reg] ? ram_rdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            distinct_reg   <= '0;
            sole_key_reg   <= NO_KEY;
            sole_valid_reg <= 1'b0;
        end else if (ctl.do_clear) begin
            slot_valid_reg <= '0;
            distinct_reg   <= '0;
            sole_key_reg   <= NO_KEY;
            sole_valid_reg <= 1'b0;
        end else if (ctl.do_roll) begin
            // A rolling key either takes its slot with one vote or, when it has
            // no slot, is held as the sole entry.
            distinct_reg <= KEY_W'(1);
            if (s_in_slot) begin
                slot_valid_reg <= KEY_SLOTS'(1) << s_slot;
                sole_key_reg   <= NO_KEY;
                sole_valid_reg <= 1'b0;
            end else begin
                slot_valid_reg <= '0;
                sole_key_reg   <= s_key;
                sole_valid_reg <= 1'b1;
            end
        end else if (ctl.upd) begin
            slot_valid_reg[key_slot_reg] <= 1'b1;
            if ((upd_count == '0) && (distinct_reg != DISTINCT_MAX)) begin
                distinct_reg <= distinct_reg + KEY_W'(1);
            end
        end
    end

    // The single read port serves the key read at acceptance and the scan.
    assign ram_we    = (ctl.do_roll && s_in_slot) || ctl.upd;
    assign ram_waddr = ctl.upd ? key_slot_reg : s_slot;
    assign ram_wdata = ctl.upd ? upd_inc : COUNT_BITS'(1);
    assign ram_re    = ctl.rd_key || ctl.scan_issue;
    assign ram_raddr = ctl.rd_key ? s_slot : idx_reg[SLOT_W-1:0];

    kvh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (KEY_SLOTS)
    ) u_counts (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Capture the request at acceptance. A query reports a zero frequency.
    always_ff @(posedge aclk) begin
        if (acc) begin
            key_reg      <= s_key;
            key_slot_reg <= s_slot;
            freq_reg     <= (s_req.func == FUNC_QUERY) ? '0 : s_req.frequency_word;
            echo_reg     <= ctl.do_roll;
        end
    end

    // Scan issue counter and the read that is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ctl.scan_issue;
            if (ctl.scan_init) begin
                idx_reg <= '0;
            end else if (ctl.scan_issue) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.scan_issue) begin
            addr_reg <= idx_reg[SLOT_W-1:0];
        end
    end

    assign vote_ctl.init = ctl.scan_init;
    assign vote_ctl.cmp  = pend_reg;

    kvh_vote #(
        .SLOT_W     (SLOT_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_vote (
        .aclk       (aclk),
        .ctl        (vote_ctl),
        .rd_count   (scan_count),
        .rd_addr    (addr_reg),
        .sole_key   (sole_key_reg),
        .sole_valid (sole_valid_reg),
        .distinct   (distinct_reg),
        .vote       (vote)
    );

    // Output register: loaded only when empty or being emptied in this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_res_reg.voted_key     <= echo_reg ? key_reg : vote;
            m_res_reg.frequency_out <= freq_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/kvh_chk.sv =====
`default_nettype none

module kvh_chk
    import kvh_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire kvh_in_t  s_req,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire kvh_out_t m_res
);

    // Reset drops any pending result.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_res)))
        else $error("stalled result changed");

    // Key and query requests leave the block busy in the cycle after acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req.func == FUNC_KEY || s_req.func == FUNC_QUERY))
        |=> !s_ready)
        else $error("ready right after a key or query request");

    // A clear request completes in the cycle it is accepted.
    a_clear_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req.func == FUNC_CLEAR) |=> s_ready)
        else $error("clear request left the block busy");

    // A new result appears only out of a busy cycle.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while idle");

endmodule

bind key_vote_histogram_top kvh_chk u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import kvh_pkg::*;

    // Block sizes; these match the defaults of the block.
    localparam int KEY_SLOTS  = 128;
    localparam int COUNT_BITS = 16;

    // The package names no code for the unused function value. The block ignores it.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // SETTLE covers the longest request, a record-mode key request with its scan,
    // plus margin, for requests that finish without handing over a result.
    localparam int unsigned SETTLE       = KEY_SLOTS + 16;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int          PHASES       = 12;
    localparam int          PHASE_ITEMS  = 120;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    kvh_in_t               s_req     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    kvh_out_t              m_res;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    key_vote_histogram_top #(
        .KEY_SLOTS (KEY_SLOTS),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Vote predictor. It keeps its own copy of the store and the settings
    // and computes the result of each request at the moment it is accepted.
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0]   vote_tally [KEY_SLOTS];
    logic [7:0]              distinct_count;
    logic signed [KEY_W-1:0] lone_key;
    logic                    lone_valid;
    logic                    rolling_on;
    logic [7:0]              key_limit;

    // Results still owed by the block, oldest first.
    kvh_out_t    expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Stall control of the two sides, changed from phase to phase.
    bit          sender_steady = 1'b0;
    bit          sink_steady   = 1'b0;
    int unsigned sink_hold     = 0;

    function automatic void empty_store();
        foreach (vote_tally[i]) vote_tally[i] = '0;
        distinct_count = '0;
        lone_key       = NO_KEY;
        lone_valid     = 1'b0;
    endfunction

    // The lowest key with the top count wins, but only when that count
    // exceeds half the number of distinct keys (rounded down). A rolling key
    // that has no slot counts once. A negative one sorts ahead of every slot.
    function automatic logic signed [KEY_W-1:0] majority_key();
        int unsigned top_count;
        int          top_key;
        int          slot;
        top_count = 0;
        top_key   = -1;
        if (distinct_count == 0) begin
            return NO_KEY;
        end
        if (lone_valid && lone_key < 0) begin
            top_count = 1;
            top_key   = lone_key;
        end
        for (slot = 0; slot < KEY_SLOTS; slot++) begin
            if (vote_tally[slot] > top_count) begin
                top_count = vote_tally[slot];
                top_key   = slot;
            end
        end
        if (lone_valid && lone_key >= 0 && top_count < 1) begin
            top_count = 1;
            top_key   = lone_key;
        end
        if (top_count > (distinct_count >> 1)) begin
            return top_key[KEY_W-1:0];
        end
        return NO_KEY;
    endfunction

    function automatic void predict_request(input kvh_in_t req, output bit produces,
                                            output kvh_out_t res);
        int k;
        k        = $signed(req.key_index);
        produces = 1'b0;
        res      = '0;
        case (req.func)
            FUNC_CLEAR: begin
                empty_store();
            end
            FUNC_QUERY: begin
                produces      = 1'b1;
                res.voted_key = majority_key();
            end
            FUNC_KEY: begin
                produces          = 1'b1;
                res.frequency_out = req.frequency_word;
                if (rolling_on) begin
                    empty_store();
                    if (k >= 0 && k < KEY_SLOTS) begin
                        vote_tally[k] = 1;
                    end else begin
                        lone_key   = req.key_index;
                        lone_valid = 1'b1;
                    end
                    distinct_count = 1;
                    res.voted_key  = req.key_index;
                end else begin
                    if (k >= 0 && k < int'(key_limit) && k < KEY_SLOTS) begin
                        if (vote_tally[k] == 0 && distinct_count != DISTINCT_MAX) begin
                            distinct_count++;
                        end
                        if (vote_tally[k] != '1) begin
                            vote_tally[k]++;
                        end
                    end
                    res.voted_key = majority_key();
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at cycle %0d: %s: got 0x%0h, expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every result taken from the m_ channel is compared
    // with the oldest outstanding expectation. Values read right after the
    // edge are the ones that were present at the edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        kvh_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending", m_res.voted_key, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_res.voted_key !== want.voted_key) begin
                    report_mismatch("voted_key", m_res.voted_key, want.voted_key);
                end
                if (m_res.frequency_out !== want.frequency_out) begin
                    report_mismatch("frequency_out", m_res.frequency_out, want.frequency_out);
                end
            end
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(40, 200);
    endfunction

    // The receiver drops ready for stretches of random length. During a
    // steady phase it keeps ready high throughout.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_steady || $urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready   <= 1'b0;
            sink_hold <= idle_len();
        end
    end

    // The watchdog ends a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Each task starts and ends right after a rising edge, so
    // that every input changes only through one nonblocking assignment per
    // edge.
    // ------------------------------------------------------------------

    // Present one request and hold it until accepted. The expectation is
    // recorded at the edge that accepts it. A pinned result, where given,
    // stands in for the predicted one.
    task automatic send_request(input kvh_in_t req, input bit pinned,
                                input kvh_out_t pinned_res);
        bit       produces;
        kvh_out_t res;
        s_valid <= 1'b1;
        s_req   <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_request(req, produces, res);
        if (produces) begin
            if (pinned) begin
                res = pinned_res;
            end
            expected_results = {expected_results, res};
        end
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stop sending until every outstanding result has come or DRAIN_LIMIT is reached.
    // Then wait out the settle argument for requests that finish without a result.
    task automatic wait_results(input int unsigned settle);
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (settle) @(posedge aclk);
    endtask

    // A register write takes effect at the edge at which the enable is seen.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_ROLLING) begin
            rolling_on = val[0];
        end else begin
            key_limit = val;
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Directed script: a row is either a register write or a request. A row
    // that pins a result carries a value that is plain to see. Every other
    // row is checked against the predictor.
    // ------------------------------------------------------------------
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        kvh_in_t               req;
        bit                    pinned;
        kvh_out_t              pinned_res;
    } script_row_t;

    script_row_t script[$];

    function automatic void add_request(input logic [FUNC_W-1:0] func,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [FREQ_W-1:0] freq);
        script_row_t row;
        row                    = '{default: '0};
        row.req.func           = func;
        row.req.key_index      = key;
        row.req.frequency_word = freq;
        script = {script, row};
    endfunction

    function automatic void add_pinned(input logic [FUNC_W-1:0] func,
                                       input logic signed [KEY_W-1:0] key,
                                       input logic [FREQ_W-1:0] freq,
                                       input logic signed [KEY_W-1:0] voted,
                                       input logic [FREQ_W-1:0] freq_out);
        add_request(func, key, freq);
        script[$].pinned                   = 1'b1;
        script[$].pinned_res.voted_key     = voted;
        script[$].pinned_res.frequency_out = freq_out;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        script = {script, row};
    endfunction

    // Random request. Most key requests repeat a favorite key so that
    // majorities form. Clears are frequent enough to reset the count of
    // distinct keys now and then.
    function automatic kvh_in_t random_request(input logic signed [KEY_W-1:0] favorite);
        kvh_in_t     req;
        int unsigned pick;
        int unsigned span;
        span = (key_limit == 0 || key_limit > KEY_SLOTS) ? KEY_SLOTS : key_limit;
        req.frequency_word = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            req.func = FUNC_UNUSED;
        end else if (pick < 7) begin
            req.func = FUNC_CLEAR;
        end else if (pick < 20) begin
            req.func = FUNC_QUERY;
        end else begin
            req.func = FUNC_KEY;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            req.key_index = favorite;
        end else if (pick < 80) begin
            req.key_index = KEY_W'($urandom_range(0, span - 1));
        end else if (pick < 90) begin
            req.key_index = KEY_W'($urandom_range(0, 127));
        end else begin
            req.key_index = KEY_W'($urandom_range(128, 255));
        end
        return req;
    endfunction

    initial begin
        kvh_in_t                 req;
        kvh_out_t                none;
        logic signed [KEY_W-1:0] favorite;
        logic [7:0]              phase_keys [PHASES];
        int                      ph;
        int                      sent;
        int unsigned             span;

        none = '0;
        phase_keys = '{8'd88, 8'd1, 8'd128, 8'd0, 8'd255, 8'd128,
                       8'd2, 8'd0, 8'd128, 8'd1, 8'd64, 8'd200};

        rolling_on = 1'b0;
        key_limit  = NUM_KEYS_RESET;
        empty_store();

        // Record mode with 88 keys after reset.
        add_pinned(FUNC_QUERY, 8'sd0, 32'h0000_0000, NO_KEY, 32'h0);
        add_pinned(FUNC_KEY, 8'sd0, 32'hFFFF_FFFF, 8'sd0, 32'hFFFF_FFFF);
        // Two keys with one vote each: a tie is no majority.
        add_pinned(FUNC_KEY, 8'sd87, 32'h0000_0000, NO_KEY, 32'h0);
        // Keys past the limit or negative are not counted.
        add_pinned(FUNC_KEY, 8'sd88, 32'h1234_5678, NO_KEY, 32'h1234_5678);
        add_pinned(FUNC_KEY, 8'sd127, 32'h8000_0001, NO_KEY, 32'h8000_0001);
        add_pinned(FUNC_KEY, -8'sd1, 32'h7FFF_FFFE, NO_KEY, 32'h7FFF_FFFE);
        add_pinned(FUNC_KEY, -8'sd128, 32'hDEAD_BEEF, NO_KEY, 32'hDEAD_BEEF);
        add_pinned(FUNC_KEY, 8'sd87, 32'h5A5A_5A5A, 8'sd87, 32'h5A5A_5A5A);
        add_request(FUNC_UNUSED, 8'sd0, 32'h0000_0000);
        add_pinned(FUNC_QUERY, 8'sd5, 32'hFFFF_FFFF, 8'sd87, 32'h0);
        add_request(FUNC_CLEAR, 8'sd0, 32'hFFFF_FFFF);
        add_pinned(FUNC_QUERY, 8'sd0, 32'h0, NO_KEY, 32'h0);
        // The top of the key range, then no key counted at all, then a limit
        // past the slot count.
        add_write(REG_NUM_KEYS, 8'd128);
        add_pinned(FUNC_KEY, 8'sd127, 32'h0000_0001, 8'sd127, 32'h0000_0001);
        add_write(REG_NUM_KEYS, 8'd0);
        add_request(FUNC_KEY, 8'sd0, 32'h0000_0002);
        add_write(REG_NUM_KEYS, 8'd255);
        add_request(FUNC_KEY, 8'sd100, 32'h0000_0003);
        // Rolling mode echoes each key. A negative key has no slot and is
        // held on its own.
        add_write(REG_ROLLING, 8'd1);
        add_pinned(FUNC_KEY, 8'sd5, 32'hA5A5_A5A5, 8'sd5, 32'hA5A5_A5A5);
        add_pinned(FUNC_KEY, -8'sd1, 32'h0F0F_0F0F, NO_KEY, 32'h0F0F_0F0F);
        add_request(FUNC_QUERY, 8'sd0, 32'h0);
        add_pinned(FUNC_KEY, -8'sd128, 32'hF0F0_F0F0, -8'sd128, 32'hF0F0_F0F0);
        add_request(FUNC_QUERY, 8'sd0, 32'h0);
        add_pinned(FUNC_KEY, 8'sd127, 32'h3C3C_3C3C, 8'sd127, 32'h3C3C_3C3C);
        add_pinned(FUNC_KEY, -8'sd5, 32'hC3C3_C3C3, -8'sd5, 32'hC3C3_C3C3);
        // Back to record mode while the held negative key is still present.
        add_write(REG_ROLLING, 8'd0);
        add_request(FUNC_KEY, 8'sd10, 32'h1111_1111);
        add_request(FUNC_KEY, 8'sd10, 32'h2222_2222);
        add_request(FUNC_QUERY, 8'sd0, 32'h0);
        add_request(FUNC_CLEAR, 8'sd0, 32'h0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_write) begin
                wait_results(SETTLE);
                write_register(script[i].reg_idx, script[i].reg_val);
            end else begin
                send_request(script[i].req, script[i].pinned, script[i].pinned_res);
                pause_sender(idle_len());
            end
        end

        // Random phases. Each phase starts from an idle block with its own
        // settings and its own stall pattern: some phases have no sender
        // gaps, some no receiver stalls.
        for (ph = 0; ph < PHASES; ph++) begin
            wait_results(SETTLE);
            write_register(REG_ROLLING, (ph % 4 == 2) ? 8'd1 : 8'd0);
            write_register(REG_NUM_KEYS,
                           (ph == 7) ? 8'($urandom_range(1, 128)) : phase_keys[ph]);
            sender_steady = (ph % 4 == 1);
            sink_steady   = (ph % 4 == 3);
            span = (key_limit == 0 || key_limit > KEY_SLOTS) ? KEY_SLOTS : key_limit;
            favorite = KEY_W'($urandom_range(0, span - 1));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 5) begin
                    favorite = ($urandom_range(0, 9) < 8) ?
                               KEY_W'($urandom_range(0, span - 1)) : KEY_W'($urandom());
                end
                req = random_request(favorite);
                send_request(req, 1'b0, none);
                if (req.func != FUNC_UNUSED) begin
                    sent++;
                end
                if (ph % 3 == 1 && sent == PHASE_ITEMS / 2) begin
                    // Let the block run dry before the second half of the
                    // phase.
                    wait_results(0);
                end else begin
                    pause_sender(sender_steady ? 0 : idle_len());
                end
            end
        end

        wait_results(SETTLE);
        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", expected_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== key_vote_histogram_top.f =====
hw/rtl/kvh_pkg.sv
hw/rtl/kvh_ram.sv
hw/rtl/kvh_vote.sv
hw/rtl/kvh_seq.sv
hw/rtl/key_vote_histogram_top.sv
hw/rtl/kvh_chk.sv
sim/tb.sv
